// ===== design/tgfb_pkg.sv =====
// ----------------------------------------------------------------------------
// tgfb_pkg
// Shared types, constants and the 5x8 glyph table for the text framebuffer.
// ----------------------------------------------------------------------------
package tgfb_pkg;

    // default geometry
    localparam int DEF_COLUMNS     = 128;
    localparam int DEF_PAGES       = 8;
    localparam int DEF_CHUNK_BYTES = 16;

    // width of the address arithmetic done when an item is taken
    localparam int CALC_W = 16;

    // font geometry and fill patterns
    localparam int         GLYPH_W    = 5;
    localparam int         CELL_PITCH = 6;
    localparam logic [7:0] CODE_LO    = 8'h20;
    localparam logic [7:0] CODE_HI    = 8'h7E;
    localparam logic [7:0] LINE_BYTE  = 8'h01;
    localparam logic [7:0] BLANK_BYTE = 8'h00;

    // operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_CHAR  = 2'd1,
        OP_LINE  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic init;
        logic load;
        logic write_step;
        logic read_issue;
    } tgfb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic remain_zero;
        logic slot_free;
        logic rd_busy;
    } tgfb_status_t;

    // five glyph columns, index 0 is the leftmost column
    typedef logic [0:4][7:0] glyph_t;

    // font table, glyph index is code minus 0x20
    function automatic glyph_t glyph_row(input logic [6:0] idx);
        glyph_t row;
        unique case (idx)
            7'd0:  row = 40'h0000000000;
            7'd1:  row = 40'h00005F0000;
            7'd2:  row = 40'h0007000700;
            7'd3:  row = 40'h147F147F14;
            7'd4:  row = 40'h242A7F2A12;
            7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250;
            7'd7:  row = 40'h0005030000;
            7'd8:  row = 40'h001C224100;
            7'd9:  row = 40'h0041221C00;
            7'd10: row = 40'h082A1C2A08;
            7'd11: row = 40'h08083E0808;
            7'd12: row = 40'h0050300000;
            7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0060600000;
            7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3E5149453E;
            7'd17: row = 40'h00427F4000;
            7'd18: row = 40'h4261514946;
            7'd19: row = 40'h2141454B31;
            7'd20: row = 40'h1814127F10;
            7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3C4A494930;
            7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936;
            7'd25: row = 40'h064949291E;
            7'd26: row = 40'h0036360000;
            7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0008142241;
            7'd29: row = 40'h1414141414;
            7'd30: row = 40'h4122140800;
            7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413E;
            7'd33: row = 40'h7E1111117E;
            7'd34: row = 40'h7F49494936;
            7'd35: row = 40'h3E41414122;
            7'd36: row = 40'h7F4141221C;
            7'd37: row = 40'h7F49494941;
            7'd38: row = 40'h7F09090901;
            7'd39: row = 40'h3E4149497A;
            7'd40: row = 40'h7F0808087F;
            7'd41: row = 40'h00417F4100;
            7'd42: row = 40'h2040413F01;
            7'd43: row = 40'h7F08142241;
            7'd44: row = 40'h7F40404040;
            7'd45: row = 40'h7F0204027F;
            7'd46: row = 40'h7F0408107F;
            7'd47: row = 40'h3E4141413E;
            7'd48: row = 40'h7F09090906;
            7'd49: row = 40'h3E4151215E;
            7'd50: row = 40'h7F09192946;
            7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017F0101;
            7'd53: row = 40'h3F4040403F;
            7'd54: row = 40'h1F2040201F;
            7'd55: row = 40'h3F4038403F;
            7'd56: row = 40'h6314081463;
            7'd57: row = 40'h0708700807;
            7'd58: row = 40'h6151494543;
            7'd59: row = 40'h007F414100;
            7'd60: row = 40'h0204081020;
            7'd61: row = 40'h0041417F00;
            7'd62: row = 40'h0402010204;
            7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0001020400;
            7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7F48444438;
            7'd67: row = 40'h3844444420;
            7'd68: row = 40'h384444487F;
            7'd69: row = 40'h3854545418;
            7'd70: row = 40'h087E090102;
            7'd71: row = 40'h081454543C;
            7'd72: row = 40'h7F08040478;
            7'd73: row = 40'h00447D4000;
            7'd74: row = 40'h2040443D00;
            7'd75: row = 40'h7F10284400;
            7'd76: row = 40'h00417F4000;
            7'd77: row = 40'h7C04180478;
            7'd78: row = 40'h7C08040478;
            7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7C14141408;
            7'd81: row = 40'h081414187C;
            7'd82: row = 40'h7C08040408;
            7'd83: row = 40'h4854545420;
            7'd84: row = 40'h043F444020;
            7'd85: row = 40'h3C4040407C;
            7'd86: row = 40'h1C2040201C;
            7'd87: row = 40'h3C4020403C;
            7'd88: row = 40'h4428102844;
            7'd89: row = 40'h0C5050503C;
            7'd90: row = 40'h4464544C44;
            7'd91: row = 40'h0008364100;
            7'd92: row = 40'h00007F0000;
            7'd93: row = 40'h0041360800;
            7'd94: row = 40'h08082A1C08;
            default: row = 40'h0000000000;
        endcase
        return row;
    endfunction

endpackage

// ===== design/tgfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgfb_ctrl
// Sequencer for the text framebuffer: takes one item at a time and steps the
// datapath through its write or read run.
// ----------------------------------------------------------------------------
module tgfb_ctrl
    import tgfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  op_t          in_opcode,
    input  tgfb_status_t status,
    output tgfb_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_WRITE,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_opcode == OP_READ) ? ST_READ : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (status.remain_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.write_step = 1'b1;
                end
            end
            ST_READ:
            begin
                if (status.remain_zero)
                begin
                    if (!status.rd_busy)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.read_issue = status.slot_free;
                end
            end
        endcase
    end

    // state and ready register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

// ===== design/tgfb_datapath.sv =====
// ----------------------------------------------------------------------------
// tgfb_datapath
// Framebuffer memory, run address and count, glyph lookup, read pipeline and
// output register.
// ----------------------------------------------------------------------------
module tgfb_datapath
    import tgfb_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int PAGES       = DEF_PAGES,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  tgfb_cmd_t    cmd,
    output tgfb_status_t status,
    input  op_t          opcode,
    input  logic [4:0]   cell_column,
    input  logic [2:0]   page_row,
    input  logic [7:0]   char_code,
    input  logic [5:0]   chunk_index,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   pixel_byte,
    output logic         last_of_chunk,
    output logic         last_of_frame
);

    localparam int STORE = COLUMNS * PAGES;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(STORE + 1);
    localparam int LW    = CALC_W;

    // framebuffer
    logic [7:0] mem [STORE];
    logic [7:0] mem_q_reg;

    // run registers
    logic [AW-1:0] addr_reg;
    logic [CW-1:0] remain_reg;
    logic [2:0]    col_reg;
    logic [6:0]    glyph_reg;
    op_t           kind_reg;

    // read pipeline and output register
    logic rd_valid_reg;
    logic rd_last_chunk_reg;
    logic rd_last_frame_reg;
    logic out_valid_reg;
    logic [7:0] out_byte_reg;
    logic out_last_chunk_reg;
    logic out_last_frame_reg;

    // load values
    logic [LW-1:0] page_base;
    logic [LW-1:0] cell_x;
    logic [LW-1:0] glyph_end;
    logic [LW-1:0] chunk_start;
    logic [LW-1:0] bytes_left;
    logic [LW-1:0] chunk_len;
    logic          page_ok;
    logic [AW-1:0] load_addr;
    logic [CW-1:0] load_remain;
    logic [6:0]    load_glyph;

    logic   [7:0]  write_byte;
    glyph_t        cur_row;
    logic          out_load;
    logic          remain_zero;

    // address and run length for the item being taken
    always_comb
    begin
        page_base   = LW'(page_row) * LW'(COLUMNS);
        cell_x      = LW'(cell_column) * LW'(CELL_PITCH);
        glyph_end   = cell_x + LW'(GLYPH_W);
        chunk_start = LW'(chunk_index) * LW'(CHUNK_BYTES);
        bytes_left  = LW'(STORE) - chunk_start;
        chunk_len   = (bytes_left < LW'(CHUNK_BYTES)) ? bytes_left : LW'(CHUNK_BYTES);
        page_ok     = (LW'(page_row) < LW'(PAGES));
        load_glyph  = '0;
        if ((char_code >= CODE_LO) && (char_code <= CODE_HI))
        begin
            load_glyph = 7'(char_code - CODE_LO);
        end
        load_addr   = '0;
        load_remain = '0;
        unique case (opcode)
            OP_CLEAR:
            begin
                load_remain = CW'(STORE);
            end
            OP_CHAR:
            begin
                load_addr = AW'(page_base + cell_x);
                if (page_ok && (glyph_end <= LW'(COLUMNS)))
                begin
                    // spacer column dropped when the glyph touches the right edge
                    load_remain = (glyph_end < LW'(COLUMNS)) ? CW'(GLYPH_W + 1)
                                                             : CW'(GLYPH_W);
                end
            end
            OP_LINE:
            begin
                load_addr = AW'(page_base);
                if (page_ok)
                begin
                    load_remain = CW'(COLUMNS);
                end
            end
            OP_READ:
            begin
                load_addr = AW'(chunk_start);
                if (chunk_start < LW'(STORE))
                begin
                    load_remain = CW'(chunk_len);
                end
            end
        endcase
    end

    // byte written on each write step
    always_comb
    begin
        cur_row    = glyph_row(glyph_reg);
        write_byte = BLANK_BYTE;
        unique case (kind_reg)
            OP_CLEAR: write_byte = BLANK_BYTE;
            OP_LINE:  write_byte = LINE_BYTE;
            OP_CHAR:
            begin
                if (col_reg < 3'(GLYPH_W))
                begin
                    write_byte = cur_row[col_reg];
                end
            end
            OP_READ:  write_byte = BLANK_BYTE;
        endcase
    end

    // run address, count and glyph column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            remain_reg <= '0;
            col_reg    <= '0;
            glyph_reg  <= '0;
            kind_reg   <= OP_CLEAR;
        end
        else if (cmd.init)
        begin
            addr_reg   <= '0;
            remain_reg <= CW'(STORE);
            col_reg    <= '0;
            kind_reg   <= OP_CLEAR;
        end
        else if (cmd.load)
        begin
            addr_reg   <= load_addr;
            remain_reg <= load_remain;
            col_reg    <= '0;
            glyph_reg  <= load_glyph;
            kind_reg   <= opcode;
        end
        else if (cmd.write_step || cmd.read_issue)
        begin
            addr_reg   <= addr_reg + AW'(1);
            remain_reg <= remain_reg - CW'(1);
            col_reg    <= col_reg + 3'd1;
        end
    end

    // single port memory, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.write_step)
        begin
            mem[addr_reg] <= write_byte;
        end
        if (cmd.read_issue)
        begin
            mem_q_reg <= mem[addr_reg];
        end
    end

    // read pipeline: a byte moves on when the output register is free
    assign out_load    = rd_valid_reg && (!out_valid_reg || out_ready);
    assign remain_zero = (remain_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.read_issue || (rd_valid_reg && !out_load);
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    // flags travel beside the read data
    always_ff @(posedge clk)
    begin
        if (cmd.read_issue)
        begin
            rd_last_chunk_reg <= (remain_reg == CW'(1));
            rd_last_frame_reg <= (addr_reg == AW'(STORE - 1));
        end
        if (out_load)
        begin
            out_byte_reg       <= mem_q_reg;
            out_last_chunk_reg <= rd_last_chunk_reg;
            out_last_frame_reg <= rd_last_frame_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.remain_zero = remain_zero;
        status.slot_free   = !rd_valid_reg || out_load;
        status.rd_busy     = rd_valid_reg;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_byte    = out_byte_reg;
    assign last_of_chunk = out_last_chunk_reg;
    assign last_of_frame = out_last_frame_reg;

endmodule

// ===== design/text_glyph_framebuffer_engine.sv =====
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_engine
// Page-mode monochrome text framebuffer with a 5x8 font and chunked readout.
// ----------------------------------------------------------------------------
// The block holds a COLUMNS x PAGES byte framebuffer in one single-port memory
// and handles one item at a time, at most one memory access per cycle. After
// reset it runs a clearing pass of COLUMNS*PAGES writes, with tready low until
// the pass is done. A put character writes five glyph columns and a spacer, a
// horizontal line COLUMNS bytes, a clear COLUMNS*PAGES bytes, and a read chunk
// up to CHUNK_BYTES bytes; the read stalls with backpressure. Skipped requests
// write nothing.
// The last results of a read may still wait in the output register while the
// next item is taken.
module text_glyph_framebuffer_engine
    import tgfb_pkg::*;
#(
    parameter int COLUMNS     = DEF_COLUMNS,
    parameter int PAGES       = DEF_PAGES,
    parameter int CHUNK_BYTES = DEF_CHUNK_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // cell_column, page_row, char_code, chunk_index
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // pixel_byte
    output logic        m_axis_tlast,  // last_of_chunk
    output logic        m_axis_tuser   // last_of_frame
);

    tgfb_cmd_t    cmd;
    tgfb_status_t status;
    op_t          opcode;

    assign opcode = op_t'(s_axis_tuser);

    // sequencer
    tgfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (opcode),
        .status    (status),
        .cmd       (cmd)
    );

    // memory and datapath
    tgfb_datapath #(
        .COLUMNS     (COLUMNS),
        .PAGES       (PAGES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .cell_column   (s_axis_tdata[4:0]),
        .page_row      (s_axis_tdata[7:5]),
        .char_code     (s_axis_tdata[15:8]),
        .chunk_index   (s_axis_tdata[21:16]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pixel_byte    (m_axis_tdata),
        .last_of_chunk (m_axis_tlast),
        .last_of_frame (m_axis_tuser)
    );

    // the final framebuffer byte always closes its chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("last_of_frame without last_of_chunk");

    // a new item is only taken once the previous run has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (status.remain_zero && !status.rd_busy))
        else $error("input ready while a run is still active");

    // memory is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_step && cmd.read_issue))
        else $error("write and read issued together");

    // a read issue always finds room in the read pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_issue |-> status.slot_free)
        else $error("read issued with the pipeline full");

endmodule
